// File: design/deadline_event_slot_scheduler_unit_assert.svh
// Assertion helpers, sampled on the rising edge of clk, off while rst_n is low.
`ifndef DEADLINE_EVENT_SLOT_SCHEDULER_UNIT_ASSERT_SVH
`define DEADLINE_EVENT_SLOT_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define DESS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DESS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/dess_pkg.sv
`timescale 1ns / 1ps
package dess_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int OP_W       = 2;
  localparam int SLOT_ID_W  = 6;
  localparam int CYCLE_W    = 64;
  localparam int IN_DATA_W  = 72;  // slot_id + cycle_value, padded to bytes
  localparam int OUT_DATA_W = 72;  // fired_slot + next_deadline, padded to bytes

  localparam logic [CYCLE_W-1:0] NONE_DEADLINE = {CYCLE_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_SCHEDULE = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_DISPATCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // item accepted this cycle
    logic scan_en;   // walk the slots
    logic emit_adv;  // move the emit pointer
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;   // last slot compared this cycle
    logic none_fired;  // dispatch fired nothing (or not a dispatch)
    logic cur_fired;   // emit pointer sits on a fired slot
    logic last_res;    // current result is the final one of the item
  } dp_stat_t;

endpackage

// File: design/dess_ram.sv
`timescale 1ns / 1ps
module dess_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/dess_ctrl.sv
`timescale 1ns / 1ps
module dess_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  dess_pkg::dp_stat_t   stat,
  output dess_pkg::ctrl_cmd_t  cmd
);
  import dess_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if ((stat.none_fired || stat.cur_fired) && out_tready && stat.last_res) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;
    cmd.load     = 1'b0;
    cmd.scan_en  = 1'b0;
    cmd.emit_adv = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      ST_EMIT: begin
        out_tvalid   = stat.none_fired || stat.cur_fired;
        // skip idle slots; step past a fired one once it is taken
        cmd.emit_adv = !stat.none_fired && (!stat.cur_fired || out_tready);
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// File: design/dess_dp.sv
`timescale 1ns / 1ps
module dess_dp #(
  parameter int SLOTS = dess_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dess_pkg::ctrl_cmd_t               cmd,
  output dess_pkg::dp_stat_t                stat,
  input  logic [dess_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [dess_pkg::OP_W-1:0]         in_tuser,
  output logic [dess_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import dess_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // input unpack
  logic [SLOT_ID_W-1:0] in_sid;
  logic [CYCLE_W-1:0]   in_cval;
  op_t                  in_op;
  logic                 sid_ok;

  assign in_sid  = in_tdata[SLOT_ID_W-1:0];
  assign in_cval = in_tdata[SLOT_ID_W +: CYCLE_W];
  assign in_op   = op_t'(in_tuser);
  assign sid_ok  = {1'b0, in_sid} < (SLOT_ID_W + 1)'(SLOTS);

  // registers
  op_t                op_r;
  logic [CYCLE_W-1:0] cval_r;
  logic [SLOTS-1:0]   active_r, active_nxt;
  logic [SLOTS-1:0]   fmask_r, fmask_nxt;
  logic [CNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic [CYCLE_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   ecnt_r, ecnt_nxt;

  // deadline store
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [CYCLE_W-1:0] rd_data;
  logic               wr_en;

  assign wr_en   = cmd.load && (in_op == OP_SCHEDULE) && sid_ok;
  assign rd_en   = cmd.scan_en && (issue_r < CNT_W'(SLOTS));
  assign rd_addr = issue_r[IDX_W-1:0];

  dess_ram #(
    .WIDTH (CYCLE_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_deadline_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_sid[IDX_W-1:0]),
    .wr_data (in_cval),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // compare stage: one slot per cycle
  logic cmp_act, fire, closer;

  assign cmp_act = cmp_vld_r && active_r[cmp_idx_r];
  assign fire    = cmp_act && (op_r == OP_DISPATCH) && (rd_data <= cval_r);
  assign closer  = cmp_act && !fire && (rd_data < best_r);

  always_comb begin
    active_nxt  = active_r;
    fmask_nxt   = fmask_r;
    fcnt_nxt    = fcnt_r;
    best_nxt    = best_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = rd_en;
    cmp_idx_nxt = rd_addr;
    pos_nxt     = pos_r;
    ecnt_nxt    = ecnt_r;

    if (cmd.load) begin
      fmask_nxt = '0;
      fcnt_nxt  = '0;
      best_nxt  = NONE_DEADLINE;
      issue_nxt = '0;
      pos_nxt   = '0;
      ecnt_nxt  = '0;
      case (in_op)
        OP_SCHEDULE: if (sid_ok) active_nxt[in_sid[IDX_W-1:0]] = 1'b1;
        OP_REMOVE:   if (sid_ok) active_nxt[in_sid[IDX_W-1:0]] = 1'b0;
        default:     active_nxt = active_r;
      endcase
    end

    if (rd_en) begin
      issue_nxt = issue_r + 1'b1;
    end

    if (fire) begin
      active_nxt[cmp_idx_r] = 1'b0;
      fmask_nxt[cmp_idx_r]  = 1'b1;
      fcnt_nxt              = fcnt_r + 1'b1;
    end
    if (closer) begin
      best_nxt = rd_data;
    end

    if (cmd.emit_adv) begin
      pos_nxt = pos_r + 1'b1;
      if (fmask_r[pos_r]) ecnt_nxt = ecnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= '0;
      best_r    <= NONE_DEADLINE;
      cmp_vld_r <= 1'b0;
      fcnt_r    <= '0;
      issue_r   <= '0;
    end else begin
      active_r  <= active_nxt;
      best_r    <= best_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      fcnt_r    <= fcnt_nxt;
      issue_r   <= issue_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      cval_r <= in_cval;
    end
    fmask_r   <= fmask_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    pos_r     <= pos_nxt;
    ecnt_r    <= ecnt_nxt;
  end

  // status
  assign stat.scan_done  = cmp_vld_r && (cmp_idx_r == IDX_W'(SLOTS - 1));
  assign stat.none_fired = (fcnt_r == '0);
  assign stat.cur_fired  = fmask_r[pos_r];
  assign stat.last_res   = stat.none_fired || (CNT_W'(ecnt_r + 1'b1) == fcnt_r);

  // result payload
  logic [SLOT_ID_W-1:0] out_slot;

  assign out_slot  = stat.none_fired ? '0 : SLOT_ID_W'(pos_r);
  assign out_tdata = {(OUT_DATA_W - SLOT_ID_W - CYCLE_W)'(0), best_r, out_slot};
  assign out_tuser = !stat.none_fired;
  assign out_tlast = stat.last_res;

endmodule

// File: design/deadline_event_slot_scheduler_unit.sv
`timescale 1ns / 1ps
// Earliest-deadline event slot scheduler. Keeps SLOTS slots, each an active
// flag plus a 64-bit deadline held in a small RAM. Input items (in_tuser = op):
// schedule arms slot_id with cycle_value, remove disarms slot_id, dispatch
// fires every active slot whose deadline is <= cycle_value. Slot ids at or
// above SLOTS are dropped without effect; op code 3 changes nothing. Every
// item yields results: schedule, remove and an empty dispatch give one result
// with fired clear; a dispatch that fires gives one result per fired slot in
// ascending slot order, tlast on the final one. Each result carries the
// earliest active deadline after the item (all ones when none; a deadline of
// all ones never counts as earliest). Timing: one item is worked at a time.
// After the accept cycle the controller walks the deadline RAM one slot per
// cycle through its single registered read port to fire and find the
// minimum; then the emit pointer walks the fired mask one slot per cycle,
// holding on a fired slot until the sink takes its result. No clearing pass
// after reset: a deadline only counts for an active slot, and a slot only
// turns active when its deadline is written.
`include "deadline_event_slot_scheduler_unit_assert.svh"
module deadline_event_slot_scheduler_unit #(
  parameter int SLOTS = dess_pkg::SLOTS_DEF  // 1 .. 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input items
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dess_pkg::IN_DATA_W-1:0]   in_tdata,   // [5:0] slot_id, [69:6] cycle_value
  input  logic [dess_pkg::OP_W-1:0]        in_tuser,   // [1:0] op
  // result items
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dess_pkg::OUT_DATA_W-1:0]  out_tdata,  // [5:0] fired_slot, [69:6] next_deadline
  output logic                             out_tuser,  // [0] fired
  output logic                             out_tlast   // last result of the item
);
  import dess_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencing: idle -> scan slots -> emit results
  dess_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // slot state, deadline RAM, compare and minimum tracking
  dess_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // the slot walk always sits between accept and the first result
  `DESS_ASSERT_NEXT(a_no_result_after_accept, in_tvalid && in_tready, !out_tvalid, "early result")
  // one item in flight: no accept while results are pending
  `DESS_ASSERT_NOW(a_single_item, out_tvalid, !in_tready, "accept while results pending")
  // a result without a fire is always the only, and last, one
  `DESS_ASSERT_NOW(a_nofire_is_last, out_tvalid && !out_tuser, out_tlast, "non-fire not last")
  // the final result frees the input side
  `DESS_ASSERT_NEXT(a_ready_after_last, out_tvalid && out_tready && out_tlast, in_tready, "no ready")

endmodule
